/* design/lcdsfw_pkg.sv */
// ----------------------------------------------------------------------------
// lcdsfw_pkg
// shared types, codes and frame helpers for the character lcd serial writer
// ----------------------------------------------------------------------------
package lcdsfw_pkg;

	localparam int SHADOW_DEPTH = 64;
	localparam int SHADOW_AW    = 6;
	localparam int CURSOR_W     = 6;
	localparam int FRAME_W      = 24;

	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] CMD_CLEAR  = 8'h01;
	localparam logic [7:0] ADDR_BASE  = 8'h80;

	typedef enum logic [1:0] {
		REQ_PUT_CHAR = 2'd0,
		REQ_SET_POS  = 2'd1,
		REQ_RAW_CMD  = 2'd2,
		REQ_RAW_DATA = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_FIRST  = 2'd1,
		ST_SECOND = 2'd2
	} seq_state_t;

	typedef struct packed {
		req_kind_t   req_type;
		logic [7:0]  byte_value;
		logic [1:0]  row;
		logic [3:0]  column;
	} req_item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic               is_last;
	} rsp_item_t;

	// control group from the sequencer to the shadow memory
	typedef struct packed {
		logic                 wr_en;
		logic [SHADOW_AW-1:0] wr_addr;
		logic [7:0]           wr_data;
		logic                 rd_en;
		logic [SHADOW_AW-1:0] rd_addr;
		logic                 clr;
	} shd_req_t;

	// interleaved row map: base + 0x10 for row bit 0, + 0x08 for row bit 1
	function automatic logic [7:0] disp_addr(input logic [1:0] row, input logic [2:0] col_half);
		return ADDR_BASE | {3'b000, row[0], row[1], col_half};
	endfunction

	// sync ones, rw, rs, zero, high nibble, zeros, low nibble, zeros
	function automatic logic [FRAME_W-1:0] build_frame(input logic is_data,
		input logic [7:0] value, input logic invert);
		logic [FRAME_W-1:0] f;
		f = {5'b11111, 1'b0, is_data, 1'b0, value[7:4], 4'b0000, value[3:0], 4'b0000};
		return f ^ {FRAME_W{invert}};
	endfunction

endpackage

/* design/lcdsfw_shadow.sv */
// ----------------------------------------------------------------------------
// lcdsfw_shadow
// screen shadow memory, one write and one registered read per cycle,
// per-entry valid bits so a clear takes effect at once
// ----------------------------------------------------------------------------
module lcdsfw_shadow import lcdsfw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  shd_req_t   req,
	output logic [7:0] rd_data
);

	logic [7:0]              mem [SHADOW_DEPTH];
	logic [SHADOW_DEPTH-1:0] valid_q;
	logic [7:0]              rd_raw_s1;
	logic                    rd_hit_s1;

	// entries never written since reset or clear read as space
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clr) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_raw_s1 <= mem[req.rd_addr];
			rd_hit_s1 <= valid_q[req.rd_addr];
		end
	end

	assign rd_data = rd_hit_s1 ? rd_raw_s1 : SPACE_CHAR;

endmodule

/* design/char_lcd_serial_frame_writer_unit.sv */
// ----------------------------------------------------------------------------
// char_lcd_serial_frame_writer_unit
// Turns text requests for a 4x16 character display into 24-bit serial frames
// (bit 23 first). Four request kinds: put character, set position, raw
// command and raw data. A 64-byte screen shadow and a 6-bit cursor are kept
// inside; raw command 0x01 blanks the shadow and homes the cursor. One
// request is worked at a time: after the request transfer the sequencer steps
// through ST_FIRST and, for a two-frame request, ST_SECOND, handing one frame
// per cycle, while the output is not stalled, to the single output register.
// The next request can transfer only once the sequencer is back in ST_IDLE.
// The shadowed character re-sent by set position comes from the memory read
// issued at the request transfer. cfg_wr_en / cfg_wr_data write invert_q
// (reset 1, inverts every frame bit); write it only while the unit is idle.
// ----------------------------------------------------------------------------
module char_lcd_serial_frame_writer_unit import lcdsfw_pkg::*; #(
	parameter int SCREEN_CELLS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data
);

	// cursor wrap limit, one bit wider than the cursor so 64 fits
	localparam logic [CURSOR_W:0] CELLS_LIM = (CURSOR_W+1)'(SCREEN_CELLS);

	seq_state_t state_q, state_d;

	logic                accept;
	logic                out_free;
	logic                load;
	logic                invert_q;
	logic [CURSOR_W-1:0] cursor_q;
	logic [CURSOR_W:0]   cur_inc;
	logic [CURSOR_W-1:0] cur_next;

	// captured request: value and frame kind for each of up to two frames
	logic       two_q;
	logic       data0_q;
	logic [7:0] val0_q;
	logic       data1_q;
	logic [7:0] val1_q;
	logic       mem1_q;

	shd_req_t   shd_req;
	logic [7:0] shd_rd_data;

	logic       sel_data;
	logic [7:0] sel_val;
	logic       sel_last;

	rsp_item_t  rsp_q;
	logic       rsp_valid_q;

	assign accept   = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;

	// frame inversion register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b1;
		end else if (cfg_wr_en) begin
			invert_q <= cfg_wr_data;
		end
	end

	// cursor advance with wrap at the screen size
	assign cur_inc  = {1'b0, cursor_q} + (CURSOR_W+1)'(1);
	assign cur_next = (cur_inc >= CELLS_LIM) ? '0 : cur_inc[CURSOR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (accept) begin
			unique case (req.req_type)
				REQ_PUT_CHAR: cursor_q <= cur_next;
				REQ_SET_POS:  cursor_q <= {req.row, req.column};
				REQ_RAW_CMD: begin
					if (req.byte_value == CMD_CLEAR) begin
						cursor_q <= '0;
					end
				end
				REQ_RAW_DATA: cursor_q <= cursor_q;
				default:      cursor_q <= cursor_q;
			endcase
		end
	end

	// shadow access: put char writes at the cursor, set position at an odd
	// column reads the left neighbour (column - 1 is just column with bit 0 clear)
	always_comb begin
		shd_req.wr_en   = accept && (req.req_type == REQ_PUT_CHAR);
		shd_req.wr_addr = cursor_q;
		shd_req.wr_data = req.byte_value;
		shd_req.rd_en   = accept && (req.req_type == REQ_SET_POS) && req.column[0];
		shd_req.rd_addr = {req.row, req.column[3:1], 1'b0};
		shd_req.clr     = accept && (req.req_type == REQ_RAW_CMD)
		                  && (req.byte_value == CMD_CLEAR);
	end

	lcdsfw_shadow u_shadow (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (shd_req),
		.rd_data (shd_rd_data)
	);

	// capture what each frame of the request will carry
	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (req.req_type)
				REQ_PUT_CHAR: begin
					// row boundary after the advance adds the row address command
					two_q   <= (cur_next[3:0] == 4'd0);
					data0_q <= 1'b1;
					val0_q  <= req.byte_value;
					data1_q <= 1'b0;
					val1_q  <= disp_addr(cur_next[5:4], 3'd0);
					mem1_q  <= 1'b0;
				end
				REQ_SET_POS: begin
					two_q   <= req.column[0];
					data0_q <= 1'b0;
					val0_q  <= disp_addr(req.row, req.column[3:1]);
					data1_q <= 1'b1;
					val1_q  <= val1_q;
					mem1_q  <= 1'b1;
				end
				REQ_RAW_CMD: begin
					two_q   <= 1'b0;
					data0_q <= 1'b0;
					val0_q  <= req.byte_value;
					data1_q <= data1_q;
					val1_q  <= val1_q;
					mem1_q  <= mem1_q;
				end
				default: begin
					two_q   <= 1'b0;
					data0_q <= 1'b1;
					val0_q  <= req.byte_value;
					data1_q <= data1_q;
					val1_q  <= val1_q;
					mem1_q  <= mem1_q;
				end
			endcase
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_FIRST;
				end
			end
			ST_FIRST: begin
				if (out_free) begin
					state_d = two_q ? ST_SECOND : ST_IDLE;
				end
			end
			ST_SECOND: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_stall = 1'b1;
		load      = 1'b0;
		sel_data  = data0_q;
		sel_val   = val0_q;
		sel_last  = !two_q;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
			end
			ST_FIRST: begin
				load = out_free;
			end
			ST_SECOND: begin
				load     = out_free;
				sel_data = data1_q;
				sel_val  = mem1_q ? shd_rd_data : val1_q;
				sel_last = 1'b1;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output register, separates the request side from the frame sink
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q.frame   <= build_frame(sel_data, sel_val, invert_q);
			rsp_q.is_last <= sel_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a request transfer always starts the first frame step
	a_accept_to_first: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_FIRST))
		else $error("request transfer did not start frame sequencing");

	// clear command homes the cursor
	a_clear_homes: assert property (@(posedge clk) disable iff (!arst_n)
		shd_req.clr |=> (cursor_q == '0))
		else $error("clear command left the cursor away from home");

	// first frame waits while the output register is blocked
	a_first_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIRST && !out_free) |=> (state_q == ST_FIRST))
		else $error("sequencer left first step while output was blocked");

	// the second frame is always marked last
	a_second_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SECOND && load) |=> (rsp_valid_q && rsp_q.is_last))
		else $error("second frame not marked last");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the character lcd serial frame writer. A queue of
// requests (a short directed list, then random text runs and noise) feeds a
// clocked driver; a clocked monitor compares every frame transfer with the
// frames predicted from a mirror of the screen text, cursor and invert bit.
// Both sides idle at random, the receiver once holds off for a long stretch,
// and the invert bit is rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb;
	import lcdsfw_pkg::*;

	localparam int CELLS       = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 140;
	localparam int LONG_HOLD   = 300;
	localparam int HOLD_AT     = 200;

	// logical frame pieces: five sync ones, rw low, rs
	localparam logic [23:0] SYNC_ONES = 24'hF80000;
	localparam logic [23:0] RS_DATA   = 24'h020000;

	logic      clk;
	logic      arst_n;
	logic      req_valid   = 1'b0;
	logic      req_stall;
	req_item_t req         = '0;
	logic      rsp_valid;
	logic      rsp_stall   = 1'b0;
	rsp_item_t rsp;
	logic      cfg_wr_en   = 1'b0;
	logic      cfg_wr_data = 1'b0;

	// mirror of the unit's state
	logic [7:0] mirror_text [0:CELLS-1];
	logic [5:0] mirror_cursor;
	logic       mirror_invert;

	req_item_t req_backlog [$];   // requests not yet offered
	rsp_item_t frames_due  [$];   // predicted frames, oldest first
	rsp_item_t want_rsp;

	int  errors         = 0;
	int  cycle_count    = 0;
	int  frames_checked = 0;
	int  tx_gap         = 0;
	int  rx_wait        = 0;
	int  hold_left      = 0;
	bit  held_long      = 0;
	bit  tx_burst       = 0;
	bit  rx_burst       = 0;
	bit  offer_done;

	char_lcd_serial_frame_writer_unit #(
		.SCREEN_CELLS(CELLS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// clock and a single reset pulse
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// queue one predicted frame, inverted when the invert bit is set
	function automatic void frame_due(input logic is_data, input logic [7:0] value,
		input logic last);
		rsp_item_t e;
		e.frame = SYNC_ONES | (is_data ? RS_DATA : 24'h0)
			| ({20'h0, value[7:4]} << 12) | ({20'h0, value[3:0]} << 4);
		if (mirror_invert)
			e.frame = ~e.frame;
		e.is_last = last;
		frames_due.push_back(e);
	endfunction

	// display address of the cell at a row start, interleaved row map
	function automatic logic [7:0] row_start(input logic [5:0] pos);
		return 8'h80 + (pos[4] ? 8'h10 : 8'h00) + (pos[5] ? 8'h08 : 8'h00);
	endfunction

	// apply one request to the mirror and queue the frames it causes
	function automatic void predict_frames(input req_item_t r);
		int         nxt;
		logic [7:0] addr;
		case (r.req_type)
			REQ_PUT_CHAR: begin
				mirror_text[mirror_cursor] = r.byte_value;
				nxt = int'(mirror_cursor) + 1;
				if (nxt >= CELLS)
					nxt = 0;
				mirror_cursor = nxt[5:0];
				// crossing into a new row also moves the display address
				if (mirror_cursor[3:0] == 4'h0) begin
					frame_due(1'b1, r.byte_value, 1'b0);
					frame_due(1'b0, row_start(mirror_cursor), 1'b1);
				end else begin
					frame_due(1'b1, r.byte_value, 1'b1);
				end
			end
			REQ_SET_POS: begin
				addr = 8'h80 + (r.row[0] ? 8'h10 : 8'h00) + (r.row[1] ? 8'h08 : 8'h00)
					+ {5'b0, r.column[3:1]};
				mirror_cursor = {r.row, r.column};
				// odd column: the display addresses pairs, so the left cell is re-sent
				if (r.column[0]) begin
					frame_due(1'b0, addr, 1'b0);
					frame_due(1'b1, mirror_text[{r.row, r.column[3:1], 1'b0}], 1'b1);
				end else begin
					frame_due(1'b0, addr, 1'b1);
				end
			end
			REQ_RAW_CMD: begin
				if (r.byte_value == CMD_CLEAR) begin
					foreach (mirror_text[i])
						mirror_text[i] = SPACE_CHAR;
					mirror_cursor = '0;
				end
				frame_due(1'b0, r.byte_value, 1'b1);
			end
			default: begin
				frame_due(1'b1, r.byte_value, 1'b1);
			end
		endcase
	endfunction

	// driver: offers queued requests, predicts at each accepted transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			offer_done = req_valid && !req_stall;
			if (offer_done)
				predict_frames(req);
			if (!req_valid || offer_done) begin
				if (tx_gap > 0) begin
					tx_gap--;
					req_valid <= 1'b0;
				end else if (req_backlog.size() != 0) begin
					req <= req_backlog.pop_front();
					req_valid <= 1'b1;
					// occasional switch between back-to-back and gappy offering
					if ($urandom_range(0, 29) == 0)
						tx_burst = !tx_burst;
					tx_gap = tx_burst ? 0 : $urandom_range(0, 16);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each frame transfer and draws its own stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (frames_due.size() == 0) begin
					$display("%0t: frame with none expected: frame %h last %b",
						$time, rsp.frame, rsp.is_last);
					errors++;
				end else begin
					want_rsp = frames_due.pop_front();
					if (rsp.frame !== want_rsp.frame) begin
						$display("%0t: frame expected %h got %h",
							$time, want_rsp.frame, rsp.frame);
						errors++;
					end
					if (rsp.is_last !== want_rsp.is_last) begin
						$display("%0t: is_last expected %b got %b",
							$time, want_rsp.is_last, rsp.is_last);
						errors++;
					end
				end
				frames_checked++;
				if ($urandom_range(0, 29) == 0)
					rx_burst = !rx_burst;
				rx_wait = rx_burst ? 0 : $urandom_range(0, 16);
				// one long hold-off so the unit backs up and stalls its input
				if (!held_long && frames_checked == HOLD_AT) begin
					hold_left = LONG_HOLD;
					held_long = 1;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				rx_wait--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	function automatic void add_req(input req_kind_t kind, input logic [7:0] value,
		input logic [1:0] row, input logic [3:0] column);
		req_item_t r;
		r.req_type   = kind;
		r.byte_value = value;
		r.row        = row;
		r.column     = column;
		req_backlog.push_back(r);
	endfunction

	// random fields of every kind, so the ignored ones carry noise too
	function automatic req_item_t rand_req(input req_kind_t kind);
		req_item_t r;
		r.req_type   = kind;
		r.byte_value = 8'($urandom);
		r.row        = 2'($urandom);
		r.column     = 4'($urandom);
		return r;
	endfunction

	// mostly text runs (position then characters), the rest mixed requests
	task automatic queue_random(input int count);
		int        k;
		int        run;
		int        pick;
		req_item_t r;
		k = 0;
		while (k < count) begin
			if ($urandom_range(0, 5) == 0) begin
				req_backlog.push_back(rand_req(REQ_SET_POS));
				run = $urandom_range(4, 24);
				repeat (run) req_backlog.push_back(rand_req(REQ_PUT_CHAR));
				k += run + 1;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					r = rand_req(REQ_PUT_CHAR);
				end else if (pick < 70) begin
					r = rand_req(REQ_SET_POS);
				end else if (pick < 85) begin
					r = rand_req(REQ_RAW_CMD);
					if ($urandom_range(0, 4) == 0)
						r.byte_value = CMD_CLEAR;
				end else begin
					r = rand_req(REQ_RAW_DATA);
				end
				req_backlog.push_back(r);
				k++;
			end
		end
	endtask

	// sender pause: everything offered, accepted and answered, then some slack
	task automatic wait_idle;
		while (req_backlog.size() != 0 || req_valid || frames_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_invert(input logic value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		mirror_invert = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		foreach (mirror_text[i])
			mirror_text[i] = SPACE_CHAR;
		mirror_cursor = '0;
		mirror_invert = 1'b1;

		wait (arst_n === 1'b1);
		@(negedge clk);

		// directed: extremes, every kind, row crossing, wrap, odd columns, clear
		add_req(REQ_RAW_DATA, 8'h00, 2'd0, 4'd0);
		add_req(REQ_RAW_DATA, 8'hFF, 2'd3, 4'd15);
		add_req(REQ_RAW_CMD, 8'h00, 2'd3, 4'd15);
		add_req(REQ_RAW_CMD, 8'hFF, 2'd0, 4'd0);
		add_req(REQ_SET_POS, 8'hFF, 2'd0, 4'd14);
		add_req(REQ_PUT_CHAR, 8'hFF, 2'd3, 4'd15);
		add_req(REQ_PUT_CHAR, 8'h00, 2'd0, 4'd0);
		add_req(REQ_SET_POS, 8'h00, 2'd0, 4'd15);
		add_req(REQ_SET_POS, 8'hA5, 2'd3, 4'd14);
		add_req(REQ_PUT_CHAR, 8'h5A, 2'd1, 4'd7);
		add_req(REQ_PUT_CHAR, 8'h41, 2'd2, 4'd9);
		add_req(REQ_SET_POS, 8'h00, 2'd3, 4'd15);
		add_req(REQ_SET_POS, 8'h00, 2'd1, 4'd0);
		add_req(REQ_SET_POS, 8'h00, 2'd2, 4'd1);
		add_req(REQ_SET_POS, 8'h00, 2'd1, 4'd3);
		add_req(REQ_PUT_CHAR, 8'h7E, 2'd0, 4'd0);
		add_req(REQ_RAW_CMD, CMD_CLEAR, 2'd2, 4'd5);
		add_req(REQ_SET_POS, 8'h00, 2'd0, 4'd15);
		add_req(REQ_SET_POS, 8'h00, 2'd3, 4'd1);
		add_req(REQ_PUT_CHAR, 8'h80, 2'd0, 4'd0);
		wait_idle();

		// random phases across both invert settings
		write_invert(1'b0);
		queue_random(PHASE_ITEMS);
		wait_idle();
		write_invert(1'b1);
		queue_random(PHASE_ITEMS);
		wait_idle();
		write_invert(1'b0);
		queue_random(PHASE_ITEMS);
		wait_idle();
		write_invert(1'b1);
		queue_random(PHASE_ITEMS);
		wait_idle();
		write_invert(1'b0);
		queue_random(PHASE_ITEMS);
		wait_idle();
		repeat (20) @(negedge clk);

		if (errors == 0 && frames_due.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/lcdsfw_pkg.sv
design/lcdsfw_shadow.sv
design/char_lcd_serial_frame_writer_unit.sv
bench/tb.sv
